// File: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the checker module.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every clock edge while reset is released.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define ASSERT_CLK_NR(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/sipc_pkg.sv
// ----------------------------------------------------------------------------
// SIP packet classifier package
// Constants, string tables and matching functions of the classifier.
// ----------------------------------------------------------------------------
package sipc_pkg;

    localparam int NUM_CMDS     = 17;
    localparam int HELLO_BIT    = 17;
    localparam int MASK_W       = 18;
    localparam int CMD_MAX_LEN  = 13;
    localparam int HELLO_LEN    = 5;

    localparam logic [15:0] STRIP_OFFSET = 16'd4;

    localparam logic [7:0]  CFG_PACKET_LIMIT   = 8'd0;
    localparam logic [7:0]  CFG_MIN_CMD_LENGTH = 8'd1;

    localparam logic [7:0]  PACKET_LIMIT_RESET   = 8'd8;
    localparam logic [15:0] MIN_CMD_LENGTH_RESET = 16'd30;

    localparam logic [1:0] VERDICT_UNDECIDED = 2'd0;
    localparam logic [1:0] VERDICT_SIP       = 2'd1;
    localparam logic [1:0] VERDICT_EXCLUDED  = 2'd2;

    localparam logic [1:0] REASON_NONE   = 2'd0;
    localparam logic [1:0] REASON_HELLO  = 2'd1;
    localparam logic [1:0] REASON_PREFIX = 2'd2;

    typedef logic [MASK_W-1:0] t_mask;

    // Strings are left-justified and padded with spaces to the longest length.
    localparam logic [8*CMD_MAX_LEN-1:0] CMD_TEXT [NUM_CMDS] = '{
        "ack sip      ", "ack tel      ", "bye sip      ", "cancel sip   ",
        "cancel tel   ", "invite sip   ", "info sip     ", "message sip  ",
        "notify sip   ", "options sip  ", "options tel  ", "publish sip  ",
        "prack sip    ", "register sip ", "refer sip    ", "subscribe sip",
        "sip/2.0      "
    };

    localparam logic [3:0] CMD_LEN [NUM_CMDS] = '{
        4'd7, 4'd7, 4'd7, 4'd10, 4'd10, 4'd10, 4'd8, 4'd11, 4'd10, 4'd11,
        4'd11, 4'd11, 4'd9, 4'd12, 4'd9, 4'd13, 4'd7
    };

    localparam logic [8*HELLO_LEN-1:0] HELLO_TEXT = "hello";

    function automatic logic [7:0] to_lower(input logic [7:0] b);
        return (b >= 8'h41 && b <= 8'h5A) ? (b + 8'h20) : b;
    endfunction

    function automatic logic is_printable(input logic [7:0] b);
        return b >= 8'h20 && b <= 8'h7E;
    endfunction

    function automatic logic [7:0] cmd_char(input int k, input logic [3:0] q);
        logic [7:0] c;
        c = 8'h00;
        if (int'(q) < CMD_MAX_LEN) begin
            c = CMD_TEXT[k][8*(CMD_MAX_LEN-1-int'(q)) +: 8];
        end
        return c;
    endfunction

    function automatic logic [7:0] hello_char(input logic [2:0] q);
        logic [7:0] c;
        c = 8'h00;
        if (int'(q) < HELLO_LEN) begin
            c = HELLO_TEXT[8*(HELLO_LEN-1-int'(q)) +: 8];
        end
        return c;
    endfunction

    // Clears each string bit whose byte at q is not b; commands ignore case.
    function automatic t_mask update_mask(input t_mask mask, input logic [15:0] q,
                                          input logic [7:0] b);
        t_mask      m;
        logic [7:0] lb;
        m  = mask;
        lb = to_lower(b);
        for (int k = 0; k < NUM_CMDS; k++) begin
            if (q < {12'd0, CMD_LEN[k]} && lb != cmd_char(k, q[3:0])) begin
                m[k] = 1'b0;
            end
        end
        if (q < 16'(HELLO_LEN) && b != hello_char(q[2:0])) begin
            m[HELLO_BIT] = 1'b0;
        end
        return m;
    endfunction

endpackage

// File: rtl/sip_packet_classifier.sv
// ----------------------------------------------------------------------------
// SIP packet classifier
// Byte-serial SIP detector with TURN ChannelData prefix handling.
// ----------------------------------------------------------------------------
// Payload bytes enter on the slave stream, one per transfer; tuser marks the
// first byte of a packet and tlast the last one. Each byte carries the packet
// length and the flow's packet count, both used at the last byte.
// Every byte is matched against all method, reply and keepalive strings on
// the plain and the prefix-stripped alignment at once.
// One result transfer leaves on the master stream for each last byte, with
// the verdict, the detection reason and the prefix flag.
// One byte is taken per cycle while the input is not stalled. A byte is held in
// the input register, and the result of a last byte is registered into the
// output register once the master side is free.
// When the master side stalls, a pending result is held; bytes that carry no
// result still move on, and the input stalls only at a last byte.
// Configuration writes are accepted at any cycle and apply to every byte that
// has not yet left the input register. The user makes them with no packet open;
// the block does not enforce this. Reset clears the pipeline, restores both
// registers to their defaults and starts with no packet in progress.
// ----------------------------------------------------------------------------
module sip_packet_classifier (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // payload_byte[7:0], packet_length[23:8], packets_seen[31:24]
    input  logic [31:0] s_axis_tdata,
    // is_first[0]
    input  logic        s_axis_tuser,
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // verdict[1:0], detect_reason[3:2], prefix_stripped[4], zero[7:5]
    output logic [7:0]  m_axis_tdata,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [7:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);
    import sipc_pkg::*;

    logic        r_s1_valid;
    logic [7:0]  r_s1_byte;
    logic        r_s1_first;
    logic        r_s1_last;
    logic [15:0] r_s1_plen;
    logic [7:0]  r_s1_seen;

    logic [15:0] r_byte_position, n_byte_position;
    logic [15:0] r_channel_length, n_channel_length;
    logic [7:0]  r_first_plain, n_first_plain;
    logic [7:0]  r_first_stripped, n_first_stripped;
    t_mask       r_mask_plain, n_mask_plain;
    t_mask       r_mask_stripped, n_mask_stripped;

    logic [7:0]  r_packet_limit;
    logic [15:0] r_min_cmd_len;

    logic        r_out_valid;
    logic [1:0]  r_out_verdict, n_out_verdict;
    logic [1:0]  r_out_reason, n_out_reason;
    logic        r_out_stripped, n_out_stripped;

    logic        out_free;
    logic        s1_go;
    logic        in_take;

    logic [15:0] p;
    logic        strip;
    logic [15:0] off;
    logic [15:0] elen;
    t_mask       mask;
    logic [7:0]  lead;
    logic        cmd_hit;

    assign out_free      = !r_out_valid || m_axis_tready;
    assign s1_go         = r_s1_valid && (!r_s1_last || out_free);
    assign s_axis_tready = !r_s1_valid || s1_go;
    assign in_take       = s_axis_tvalid && s_axis_tready;
    assign o_cfg_ready   = 1'b1;

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {3'b000, r_out_stripped, r_out_reason, r_out_verdict};

    always_comb begin
        t_mask       mp_base;
        t_mask       ms_base;
        logic [15:0] cl_base;
        logic [7:0]  fp_base;
        logic [7:0]  fs_base;

        if (r_s1_first) begin
            p       = 16'd0;
            cl_base = 16'd0;
            fp_base = 8'd0;
            fs_base = 8'd0;
            mp_base = '1;
            ms_base = '1;
        end else begin
            p       = r_byte_position;
            cl_base = r_channel_length;
            fp_base = r_first_plain;
            fs_base = r_first_stripped;
            mp_base = r_mask_plain;
            ms_base = r_mask_stripped;
        end

        n_first_plain    = (p == 16'd0) ? r_s1_byte : fp_base;
        n_first_stripped = (p == STRIP_OFFSET) ? r_s1_byte : fs_base;
        n_channel_length = cl_base;
        if (p == 16'd2) begin
            n_channel_length[15:8] = r_s1_byte;
        end
        if (p == 16'd3) begin
            n_channel_length[7:0] = r_s1_byte;
        end
        n_mask_plain    = update_mask(mp_base, p, r_s1_byte);
        n_mask_stripped = ms_base;
        if (p >= STRIP_OFFSET) begin
            n_mask_stripped = update_mask(ms_base, p - STRIP_OFFSET, r_s1_byte);
        end
        n_byte_position = (p == 16'hFFFF) ? p : p + 16'd1;

        strip = r_s1_plen > 16'd4 && (r_s1_plen - STRIP_OFFSET) == n_channel_length;
        off   = strip ? STRIP_OFFSET : 16'd0;
        elen  = strip ? r_s1_plen - STRIP_OFFSET : r_s1_plen;
        mask  = strip ? n_mask_stripped : n_mask_plain;
        lead  = strip ? n_first_stripped : n_first_plain;

        cmd_hit = 1'b0;
        for (int k = 0; k < NUM_CMDS; k++) begin
            if (mask[k] && elen > {12'd0, CMD_LEN[k]} &&
                p >= {12'd0, CMD_LEN[k]} + off - 16'd1) begin
                cmd_hit = 1'b1;
            end
        end

        n_out_verdict  = VERDICT_UNDECIDED;
        n_out_reason   = REASON_NONE;
        n_out_stripped = strip;
        if (r_s1_seen >= r_packet_limit) begin
            n_out_verdict  = VERDICT_EXCLUDED;
            n_out_stripped = 1'b0;
        end else if (r_s1_plen > 16'd4 && !is_printable(lead)) begin
            n_out_verdict = VERDICT_EXCLUDED;
        end else if (elen == 16'(HELLO_LEN) && mask[HELLO_BIT] &&
                     p >= off + 16'(HELLO_LEN - 1)) begin
            n_out_verdict = VERDICT_SIP;
            n_out_reason  = REASON_HELLO;
        end else if (elen >= r_min_cmd_len && cmd_hit) begin
            n_out_verdict = VERDICT_SIP;
            n_out_reason  = REASON_PREFIX;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid       <= 1'b0;
            r_out_valid      <= 1'b0;
            r_byte_position  <= 16'd0;
            r_channel_length <= 16'd0;
            r_first_plain    <= 8'd0;
            r_first_stripped <= 8'd0;
            r_mask_plain     <= '1;
            r_mask_stripped  <= '1;
            r_packet_limit   <= PACKET_LIMIT_RESET;
            r_min_cmd_len    <= MIN_CMD_LENGTH_RESET;
        end else begin
            if (in_take) begin
                r_s1_valid <= 1'b1;
            end else if (s1_go) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_go && r_s1_last) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            if (s1_go) begin
                r_byte_position  <= n_byte_position;
                r_channel_length <= n_channel_length;
                r_first_plain    <= n_first_plain;
                r_first_stripped <= n_first_stripped;
                r_mask_plain     <= n_mask_plain;
                r_mask_stripped  <= n_mask_stripped;
            end
            if (i_cfg_valid && o_cfg_ready) begin
                unique case (i_cfg_index)
                    CFG_PACKET_LIMIT:   r_packet_limit <= i_cfg_data[7:0];
                    CFG_MIN_CMD_LENGTH: r_min_cmd_len  <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_s1_byte  <= s_axis_tdata[7:0];
            r_s1_plen  <= s_axis_tdata[23:8];
            r_s1_seen  <= s_axis_tdata[31:24];
            r_s1_first <= s_axis_tuser;
            r_s1_last  <= s_axis_tlast;
        end
        if (s1_go && r_s1_last) begin
            r_out_verdict  <= n_out_verdict;
            r_out_reason   <= n_out_reason;
            r_out_stripped <= n_out_stripped;
        end
    end

endmodule

// File: rtl/sipc_checker.sv
// ----------------------------------------------------------------------------
// SIP packet classifier checker
// Port-level assertions on the result stream, bound to the classifier module.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sipc_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       m_axis_tvalid,
    input logic       m_axis_tready,
    input logic [7:0] m_axis_tdata
);
    import sipc_pkg::*;

    `ASSERT_CLK(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata), "Stalled result changed or dropped.")
    `ASSERT_CLK_NR(a_reset_empty, i_clk, !i_rst_n |=> !m_axis_tvalid, "Result offered right after reset.")
    `ASSERT_CLK_NR(a_reason_match, i_clk, m_axis_tvalid |-> ((m_axis_tdata[1:0] == VERDICT_SIP) == (m_axis_tdata[3:2] != REASON_NONE)), "Detection reason disagrees with verdict.")
    `ASSERT_CLK_NR(a_excluded_limit, i_clk, m_axis_tvalid && m_axis_tdata[1:0] != VERDICT_UNDECIDED && m_axis_tdata[1:0] != VERDICT_SIP |-> m_axis_tdata[1:0] == VERDICT_EXCLUDED && m_axis_tdata[3:2] == REASON_NONE, "Invalid verdict code or reason on exclusion.")

endmodule

bind sip_packet_classifier sipc_checker u_sipc_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

// File: test/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// SIP packet classifier testbench
// Streams directed and random packet payloads through the classifier with
// random sender bursts and receiver stalls. It predicts each verdict transfer
// from its own matcher over the plain and prefix-stripped alignments, and it
// compares the verdict, detection reason and prefix flag of each result with
// the oldest prediction. The run steps through several register settings,
// written only while the block is idle.
// ----------------------------------------------------------------------------
module testbench;
    import sipc_pkg::*;

    typedef struct {
        logic [7:0]  data;
        logic        first;
        logic        last;
        logic [15:0] plen;
        logic [7:0]  seen;
    } t_byte_item;

    typedef struct packed {
        logic [1:0] verdict;
        logic [1:0] reason;
        logic       stripped;
    } t_verdict;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata = '0;
    logic        s_axis_tuser = 1'b0;
    logic        s_axis_tlast = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [7:0]  m_axis_tdata;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [7:0]  i_cfg_index = '0;
    logic [15:0] i_cfg_data = '0;

    string sip_words [NUM_CMDS] = '{
        "ack sip", "ack tel", "bye sip", "cancel sip", "cancel tel",
        "invite sip", "info sip", "message sip", "notify sip", "options sip",
        "options tel", "publish sip", "prack sip", "register sip", "refer sip",
        "subscribe sip", "sip/2.0"
    };
    string greeting = "hello";

    t_byte_item  byte_items [$];
    t_verdict    verdicts_due [$];
    logic [7:0]  pkt_body [$];
    int          items_queued = 0;
    int          mismatches = 0;

    // Generator view of the registers and sender pacing.
    logic [7:0]  gen_limit = PACKET_LIMIT_RESET;
    logic [15:0] gen_min = MIN_CMD_LENGTH_RESET;
    bit          no_gaps = 1'b0;
    int          burst_left = 0;
    int          gap_left = 0;
    int          rx_count = 0;
    int          rx_hold = 0;
    int          rx_period = 0;
    logic        in_taken = 1'b0;
    logic        cfg_taken = 1'b0;

    // Predictor state and register copies.
    logic [7:0]        gate_limit = PACKET_LIMIT_RESET;
    logic [15:0]       min_len = MIN_CMD_LENGTH_RESET;
    logic [15:0]       pos = '0;
    logic [15:0]       chan_len = '0;
    logic [7:0]        lead_plain = '0;
    logic [7:0]        lead_strip = '0;
    logic [MASK_W-1:0] live_plain = '1;
    logic [MASK_W-1:0] live_strip = '1;

    sip_packet_classifier u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    function automatic logic [MASK_W-1:0] prune_words(input logic [MASK_W-1:0] live,
                                                      input int q, input logic [7:0] b);
        logic [MASK_W-1:0] m;
        logic [7:0]        lb;
        logic [7:0]        c;
        m  = live;
        lb = (b >= 8'h41 && b <= 8'h5A) ? b + 8'h20 : b;
        for (int k = 0; k < NUM_CMDS; k++) begin
            if (q < sip_words[k].len()) begin
                c = sip_words[k][q];
                if (lb != c) m[k] = 1'b0;
            end
        end
        if (q < greeting.len()) begin
            c = greeting[q];
            if (b != c) m[HELLO_BIT] = 1'b0;
        end
        return m;
    endfunction

    task automatic classify_byte(input t_byte_item it);
        int                p;
        int                got;
        int                off;
        int                elen;
        logic              strip;
        logic [MASK_W-1:0] live;
        logic [7:0]        lead;
        t_verdict          r;
        if (it.first) begin
            pos        = '0;
            chan_len   = '0;
            lead_plain = '0;
            lead_strip = '0;
            live_plain = '1;
            live_strip = '1;
        end
        p = pos;
        if (p == 0) lead_plain = it.data;
        if (p == 2) chan_len[15:8] = it.data;
        if (p == 3) chan_len[7:0] = it.data;
        if (p == 4) lead_strip = it.data;
        live_plain = prune_words(live_plain, p, it.data);
        if (p >= 4) live_strip = prune_words(live_strip, p - 4, it.data);
        got = p + 1;
        if (pos != 16'hFFFF) pos = pos + 16'd1;
        if (it.last) begin
            strip = it.plen > 16'd4 && (it.plen - 16'd4) == chan_len;
            off   = strip ? 4 : 0;
            elen  = strip ? int'(it.plen) - 4 : int'(it.plen);
            live  = strip ? live_strip : live_plain;
            lead  = strip ? lead_strip : lead_plain;
            r.verdict  = VERDICT_UNDECIDED;
            r.reason   = REASON_NONE;
            r.stripped = strip;
            if (it.seen >= gate_limit) begin
                r.verdict  = VERDICT_EXCLUDED;
                r.stripped = 1'b0;
            end else if (it.plen > 16'd4 && !(lead >= 8'h20 && lead <= 8'h7E)) begin
                r.verdict = VERDICT_EXCLUDED;
            end else if (elen == 5 && live[HELLO_BIT] && got >= off + 5) begin
                r.verdict = VERDICT_SIP;
                r.reason  = REASON_HELLO;
            end else if (elen >= int'(min_len)) begin
                for (int k = 0; k < NUM_CMDS; k++) begin
                    if (r.verdict == VERDICT_UNDECIDED && live[k] &&
                        elen > sip_words[k].len() && got >= off + sip_words[k].len()) begin
                        r.verdict = VERDICT_SIP;
                        r.reason  = REASON_PREFIX;
                    end
                end
            end
            verdicts_due.push_back(r);
        end
    endtask

    always @(posedge i_clk) begin : score
        t_verdict   want;
        t_byte_item it;
        in_taken  <= s_axis_tvalid && s_axis_tready;
        cfg_taken <= i_cfg_valid && o_cfg_ready;
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (verdicts_due.size() == 0) begin
                    $display("%0t: result with none pending, expected none, got %02h",
                             $time, m_axis_tdata);
                    mismatches++;
                end else begin
                    want = verdicts_due.pop_front();
                    if (m_axis_tdata[1:0] != want.verdict) begin
                        $display("%0t: verdict expected %0d, got %0d",
                                 $time, want.verdict, m_axis_tdata[1:0]);
                        mismatches++;
                    end
                    if (m_axis_tdata[3:2] != want.reason) begin
                        $display("%0t: detect_reason expected %0d, got %0d",
                                 $time, want.reason, m_axis_tdata[3:2]);
                        mismatches++;
                    end
                    if (m_axis_tdata[4] != want.stripped) begin
                        $display("%0t: prefix_stripped expected %0d, got %0d",
                                 $time, want.stripped, m_axis_tdata[4]);
                        mismatches++;
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready) begin
                it.data  = s_axis_tdata[7:0];
                it.plen  = s_axis_tdata[23:8];
                it.seen  = s_axis_tdata[31:24];
                it.first = s_axis_tuser;
                it.last  = s_axis_tlast;
                classify_byte(it);
            end
            if (i_cfg_valid && o_cfg_ready) begin
                if (i_cfg_index == CFG_PACKET_LIMIT) begin
                    gate_limit = i_cfg_data[7:0];
                end else if (i_cfg_index == CFG_MIN_CMD_LENGTH) begin
                    min_len = i_cfg_data;
                end
            end
        end
    end

    always @(negedge i_clk) begin : drive_bytes
        t_byte_item nxt;
        logic       go;
        if (in_taken || !s_axis_tvalid) begin
            go = 1'b0;
            if (gap_left > 0) begin
                gap_left--;
            end else if (byte_items.size() > 0) begin
                nxt = byte_items.pop_front();
                go  = 1'b1;
                if (burst_left > 0) begin
                    burst_left--;
                end else begin
                    burst_left = $urandom_range(0, 30);
                    gap_left   = no_gaps ? 0 : $urandom_range(0, 6);
                end
            end
            s_axis_tvalid <= go;
            if (go) begin
                s_axis_tdata <= {nxt.seen, nxt.plen, nxt.data};
                s_axis_tuser <= nxt.first;
                s_axis_tlast <= nxt.last;
            end
        end
    end

    always @(negedge i_clk) begin : drive_ready
        if (rx_count >= rx_period) begin
            rx_count  = 0;
            rx_hold   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            rx_period = rx_hold + $urandom_range(1, 10);
        end
        m_axis_tready <= (rx_count >= rx_hold);
        rx_count++;
    end

    function automatic logic [7:0] printable();
        return 8'($urandom_range(8'h20, 8'h7E));
    endfunction

    task automatic append_text(input string s);
        for (int i = 0; i < s.len(); i++) pkt_body.push_back(s[i]);
    endtask

    task automatic push_bytes(input bit with_first, input logic [15:0] plen,
                              input logic [7:0] seen);
        t_byte_item it;
        for (int i = 0; i < pkt_body.size(); i++) begin
            it.data  = pkt_body[i];
            it.first = with_first && i == 0;
            it.last  = (i == pkt_body.size() - 1);
            it.plen  = plen;
            it.seen  = seen;
            byte_items.push_back(it);
        end
        items_queued += pkt_body.size();
    endtask

    task automatic add_random_packet();
        int          kind;
        int          k;
        int          wl;
        int          elen;
        bit          prefixed;
        logic [15:0] plen;
        logic [15:0] chan;
        logic [7:0]  seen;
        logic [7:0]  c;
        t_byte_item  it;
        kind = $urandom_range(0, 9);
        pkt_body.delete();
        if (kind == 8) begin
            repeat ($urandom_range(1, 10)) begin
                it.data  = 8'($urandom_range(0, 255));
                it.first = ($urandom_range(0, 3) == 0);
                it.last  = ($urandom_range(0, 3) == 0);
                it.plen  = 16'($urandom_range(1, 65535));
                it.seen  = 8'($urandom_range(0, 255));
                byte_items.push_back(it);
                items_queued++;
            end
        end else begin
            if (kind <= 4) begin
                k  = $urandom_range(0, NUM_CMDS - 1);
                wl = sip_words[k].len();
                for (int i = 0; i < wl; i++) begin
                    c = sip_words[k][i];
                    if (c >= 8'h61 && c <= 8'h7A && $urandom_range(0, 1)) c = c - 8'h20;
                    pkt_body.push_back(c);
                end
                elen = wl + $urandom_range(0, 4);
                if (gen_min <= 40 && $urandom_range(0, 2) == 0) begin
                    elen = int'(gen_min) + $urandom_range(0, 2) - 1;
                end
                if (elen < 1) elen = 1;
                while (pkt_body.size() < elen) pkt_body.push_back(printable());
                while (pkt_body.size() > elen) void'(pkt_body.pop_back());
                if ($urandom_range(0, 5) == 0) begin
                    pkt_body[$urandom_range(0, elen - 1)] = 8'($urandom_range(0, 255));
                end
            end else if (kind <= 6) begin
                append_text(greeting);
                if ($urandom_range(0, 3) == 0) begin
                    pkt_body[$urandom_range(0, 4)] = $urandom_range(0, 1) ? 8'h48 :
                                                     8'($urandom_range(0, 255));
                end
                elen = ($urandom_range(0, 4) == 0) ? 6 : 5;
                if ($urandom_range(0, 3) == 0) begin
                    repeat ($urandom_range(1, 3)) pkt_body.push_back(printable());
                end
            end else begin
                elen = (kind == 9) ? $urandom_range(1, 4) : $urandom_range(1, 12);
                repeat (elen) pkt_body.push_back(8'($urandom_range(0, 255)));
            end
            prefixed = (kind != 9) && $urandom_range(0, 1);
            plen = prefixed ? 16'(elen + 4) : 16'(elen);
            if ($urandom_range(0, 7) == 0) plen = 16'($urandom_range(1, 65535));
            chan = plen - 16'd4;
            if ($urandom_range(0, 7) == 0) chan = chan + 16'd1;
            if (prefixed) begin
                pkt_body.push_front(chan[7:0]);
                pkt_body.push_front(chan[15:8]);
                pkt_body.push_front(8'($urandom_range(0, 255)));
                pkt_body.push_front($urandom_range(0, 1) ? printable() :
                                    8'($urandom_range(0, 255)));
            end
            if (pkt_body.size() > 1 && $urandom_range(0, 9) == 0) begin
                repeat ($urandom_range(1, pkt_body.size() - 1)) void'(pkt_body.pop_back());
            end
            seen = ($urandom_range(0, 4) == 0) ? 8'($urandom_range(0, 255)) :
                                                 8'($urandom_range(0, gen_limit - 1));
            push_bytes($urandom_range(0, 9) != 0, plen, seen);
        end
    endtask

    task automatic write_reg(input logic [7:0] idx, input logic [15:0] val);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(negedge i_clk); while (!cfg_taken);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic wait_idle();
        do @(posedge i_clk); while (byte_items.size() != 0 || s_axis_tvalid);
        do @(negedge i_clk); while (verdicts_due.size() != 0);
        repeat (4) @(negedge i_clk);
    endtask

    initial begin : stimulus
        int start;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // A packet that arrives without a first-byte mark after reset.
        pkt_body.delete();
        append_text(greeting);
        push_bytes(1'b0, 16'd5, 8'd0);
        pkt_body.delete();
        pkt_body.push_back(8'h00);
        push_bytes(1'b1, 16'd1, 8'd0);
        // Unprintable lead byte, fewer bytes than announced.
        pkt_body.delete();
        pkt_body.push_back(8'h7F);
        pkt_body.push_back(8'h61);
        push_bytes(1'b1, 16'd6, 8'd3);
        // Prefixed keepalive on a flow at its packet limit.
        pkt_body.delete();
        pkt_body.push_back(8'h40);
        pkt_body.push_back(8'h00);
        pkt_body.push_back(8'h00);
        pkt_body.push_back(8'h05);
        append_text(greeting);
        push_bytes(1'b1, 16'd9, 8'hFF);
        pkt_body.delete();
        pkt_body.push_back(8'hFF);
        push_bytes(1'b1, 16'hFFFF, 8'd0);
        pkt_body.delete();
        append_text("BYE sip;");
        push_bytes(1'b1, 16'd8, 8'd7);

        for (int ph = 0; ph < 6; ph++) begin
            if (ph != 0) begin
                wait_idle();
                case (ph)
                    1: begin
                        gen_limit = 8'd1;
                        gen_min   = 16'd1;
                    end
                    2: begin
                        gen_limit = 8'd255;
                        gen_min   = 16'hFFFF;
                    end
                    3: begin
                        gen_limit = 8'd255;
                        gen_min   = 16'd1;
                    end
                    4: begin
                        gen_limit = 8'($urandom_range(1, 255));
                        gen_min   = 16'($urandom_range(1, 24));
                    end
                    default: begin
                        gen_limit = PACKET_LIMIT_RESET;
                        gen_min   = 16'd12;
                    end
                endcase
                write_reg(CFG_PACKET_LIMIT, {8'd0, gen_limit});
                write_reg(CFG_MIN_CMD_LENGTH, gen_min);
            end
            no_gaps = (ph == 3);
            start = items_queued;
            while (items_queued < start + 125) add_random_packet();
        end

        wait_idle();
        repeat (10) @(negedge i_clk);
        if (mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    initial begin : watchdog
        #2_000_000;
        $display("Mismatches found");
        $finish;
    end

endmodule

// File: sip_packet_classifier.f
+incdir+rtl
rtl/sipc_pkg.sv
rtl/sip_packet_classifier.sv
rtl/sipc_checker.sv
test/testbench.sv
